// ===== design/fcull_pkg.sv =====
// shared types and constants for the frustum box cull pipeline
package fcull_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_W_DEF     = 16;

  localparam int NUM_PLANE_REGS = 6;
  localparam int PLANE_REG_W    = 64;
  localparam int NORM_W         = 16;
  localparam int OFS_W          = 16;
  // offset is Q12.4, products are Q.18, so the offset moves up by 14 bits
  localparam int OFS_SHIFT      = 14;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd5;

  // first member sits in the top bits: offset 63:48, nz 47:32, ny 31:16, nx 15:0
  typedef struct packed {
    logic signed [OFS_W-1:0]  d;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

endpackage

// ===== design/fcull_cfg_regs.sv =====
// plane register file written through the configuration channel
module fcull_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcull_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcull_pkg::PLANE_REG_W-1:0]   cfg_data,
  output fcull_pkg::plane_t                   planes [fcull_pkg::NUM_PLANE_REGS]
);
  import fcull_pkg::*;

  plane_t plane_reg [NUM_PLANE_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        plane_reg[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PLANE_NEAR:   plane_reg[0] <= plane_t'(cfg_data);
        REG_PLANE_FAR:    plane_reg[1] <= plane_t'(cfg_data);
        REG_PLANE_LEFT:   plane_reg[2] <= plane_t'(cfg_data);
        REG_PLANE_RIGHT:  plane_reg[3] <= plane_t'(cfg_data);
        REG_PLANE_TOP:    plane_reg[4] <= plane_t'(cfg_data);
        REG_PLANE_BOTTOM: plane_reg[5] <= plane_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PLANE_REGS; i++) begin
      planes[i] = plane_reg[i];
    end
  end

  a_near_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_PLANE_NEAR
    |=> plane_reg[0] == plane_t'($past(cfg_data)))
    else $error("near plane write not stored");

  a_bottom_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_PLANE_BOTTOM
    |=> plane_reg[5] == plane_t'($past(cfg_data)))
    else $error("bottom plane write not stored");

  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index > REG_PLANE_BOTTOM
    |=> $stable(plane_reg[0]) && $stable(plane_reg[5]))
    else $error("write beyond register list changed a plane");

endmodule

// ===== design/fcull_plane_eval.sv =====
// one plane: pick the farthest corner per axis, multiply, sum, sign test
module fcull_plane_eval #(
  parameter int COORD_W = fcull_pkg::COORD_W_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  fcull_pkg::plane_t         plane,
  input  logic signed [COORD_W-1:0] lo [3],
  input  logic signed [COORD_W-1:0] hi [3],
  output logic                      in_front
);
  import fcull_pkg::*;

  localparam int PROD_W = COORD_W + NORM_W;
  localparam int OFS_SH_W = OFS_W + OFS_SHIFT;
  // three products plus the shifted offset, with headroom
  localparam int SUM_W = (PROD_W + 2 > OFS_SH_W + 2) ? PROD_W + 2 : OFS_SH_W + 2;

  logic signed [NORM_W-1:0]  n   [3];
  logic signed [COORD_W-1:0] sel [3];
  logic signed [PROD_W-1:0]  prod [3];
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   prod_ext [3];
  logic signed [SUM_W-1:0]   ofs_ext;

  assign n[0] = plane.nx;
  assign n[1] = plane.ny;
  assign n[2] = plane.nz;

  // a negative normal reaches its largest distance at the low coordinate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sel[a] = n[a][NORM_W-1] ? lo[a] : hi[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        prod[a] <= n[a] * sel[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_ext[a] = {{(SUM_W-PROD_W){prod[a][PROD_W-1]}}, prod[a]};
    end
    ofs_ext = {{(SUM_W-OFS_SH_W){plane.d[OFS_W-1]}}, plane.d, {OFS_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= prod_ext[0] + prod_ext[1] + prod_ext[2] + ofs_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_front <= (sum > 0);
    end
  end

endmodule

// ===== design/frustum_aabb_cull_test_core.sv =====
// top level of the six-plane frustum test for axis-aligned boxes
// Each box transaction on the input stream gives one transaction on the output stream
// with bit 0 of tdata set when the box may be visible and clear when some enabled plane
// has every corner at a distance of zero or less. A new box is taken every cycle while the
// output is not stalled; the answer passes through five registered stages (corner ordering,
// per-axis multiply, sum, sign test, plane merge), and a stall at the output holds all five
// stages in place.
// Only the farthest corner per plane is evaluated, chosen by the normal's signs, which
// needs three 16 by COORD_WIDTH multipliers per plane. Planes are written through the
// configuration channel at indices 0 to 5 (near, far, left, right, top, bottom) and
// clear to zero on reset, so every box is culled until planes are loaded. Only the first
// PLANE_COUNT planes take part in the test.
module frustum_aabb_cull_test_core #(
  parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_DEF,
  parameter int COORD_WIDTH = fcull_pkg::COORD_W_DEF,
  parameter int IN_W        = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z, zero pad
  input  logic [IN_W-1:0]                     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // visible, zero pad
  output logic [7:0]                          m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcull_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcull_pkg::PLANE_REG_W-1:0]   cfg_data
);
  import fcull_pkg::*;

  plane_t planes [NUM_PLANE_REGS];

  logic en;
  logic v1, v2, v3, v4;
  logic visible;

  logic signed [COORD_WIDTH-1:0] box_min [3];
  logic signed [COORD_WIDTH-1:0] box_max [3];
  logic signed [COORD_WIDTH-1:0] lo [3];
  logic signed [COORD_WIDTH-1:0] hi [3];
  logic [PLANE_COUNT-1:0]        in_front;

  fcull_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // the whole pipe moves together; the output register frees it
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      box_min[a] = s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH];
      box_max[a] = s_axis_tdata[(a+3)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // start corner may lie above end corner, so order per axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (box_min[a] < box_max[a]) begin
          lo[a] <= box_min[a];
          hi[a] <= box_max[a];
        end else begin
          lo[a] <= box_max[a];
          hi[a] <= box_min[a];
        end
      end
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fcull_plane_eval #(
      .COORD_W (COORD_WIDTH)
    ) u_plane (
      .clk      (clk),
      .en       (en),
      .plane    (planes[p]),
      .lo       (lo),
      .hi       (hi),
      .in_front (in_front[p])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible <= &in_front;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      v4            <= v3;
      m_axis_tvalid <= v4;
    end
  end

  assign m_axis_tdata = {7'b0, visible};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable({v1, v2, v3, v4}))
    else $error("pipeline valid bits moved during a stall");

  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    v4 && en |=> m_axis_tvalid)
    else $error("item in last stage did not reach the output");

  a_bubble_moves: assert property (@(posedge clk) disable iff (rst)
    !v4 && en |=> !m_axis_tvalid)
    else $error("output valid without an item behind it");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted box missing from first stage");

endmodule

// ===== sim/tb_frustum_aabb_cull_test_core.sv =====
// testbench for the six-plane frustum box cull core: directed and random boxes, checked per result
module tb_frustum_aabb_cull_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fcull_pkg::*;

  localparam int CW          = COORD_W_DEF;
  localparam int IN_W        = ((6 * CW + 7) / 8) * 8;
  localparam int LATENCY     = 5;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ONE         = 1 << 14;  // 1.0 in Q1.14
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BOXES = 75;

  localparam logic [CFG_IDX_W-1:0] PLANE_IDX [NUM_PLANE_REGS] = '{
    REG_PLANE_NEAR, REG_PLANE_FAR, REG_PLANE_LEFT,
    REG_PLANE_RIGHT, REG_PLANE_TOP, REG_PLANE_BOTTOM
  };
  // indices past the last plane register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] NO_REG_LO = CFG_IDX_W'(NUM_PLANE_REGS);
  localparam logic [CFG_IDX_W-1:0] NO_REG_HI = '1;

  typedef struct {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] min_z;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic signed [CW-1:0] max_z;
  } box_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [PLANE_REG_W-1:0] cfg_data      = '0;

  plane_t plane_regs [NUM_PLANE_REGS];
  plane_t plane_plan [NUM_PLANE_REGS];
  bit     verdict_q [$];
  int     fail_count  = 0;
  int     cycle_count = 0;
  bit     tx_idles    = 1'b1;
  bit     rx_stalls   = 1'b1;
  int     rx_hold     = 0;

  frustum_aabb_cull_test_core #(
    .PLANE_COUNT(PLANE_COUNT_DEF),
    .COORD_WIDTH(CW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!rx_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (m_axis_tready && $urandom_range(0, 99) < 35) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= idle_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold       <= $urandom_range(0, 6);
    end
  end

  // a box is culled when some plane sees all eight corners at distance <= 0
  function automatic bit box_visible(box_t b);
    longint xs [2];
    longint ys [2];
    longint zs [2];
    longint corner_dist;
    bit     seen;
    xs[0] = b.min_x;  xs[1] = b.max_x;
    ys[0] = b.min_y;  ys[1] = b.max_y;
    zs[0] = b.min_z;  zs[1] = b.max_z;
    for (int p = 0; p < PLANE_COUNT_DEF && p < NUM_PLANE_REGS; p++) begin
      seen = 1'b0;
      for (int c = 0; c < 8; c++) begin
        corner_dist = longint'(plane_regs[p].nx) * xs[(c >> 2) & 1]
                    + longint'(plane_regs[p].ny) * ys[(c >> 1) & 1]
                    + longint'(plane_regs[p].nz) * zs[c & 1]
                    + (longint'(plane_regs[p].d) <<< OFS_SHIFT);
        if (corner_dist > 0) seen = 1'b1;
      end
      if (!seen) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %02h",
                 $time, m_axis_tdata);
        fail_count++;
      end else begin
        logic [7:0] want;
        want = {7'b0, verdict_q.pop_front()};
        if (m_axis_tdata !== want) begin
          $display("%0t: visible mismatch, expected %02h, actual %02h",
                   $time, want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  task automatic send_box(box_t b);
    int gap;
    gap = (!tx_idles || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({b.max_z, b.max_y, b.max_x, b.min_z, b.min_y, b.min_x});
    do @(posedge clk); while (!s_axis_tready);
    verdict_q.push_back(box_visible(b));
  endtask

  // stop the input and let the pipeline empty before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PLANE_REG_W-1:0] val, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_PLANE_REGS) plane_regs[idx] = val;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_planes();
    for (int i = 0; i < NUM_PLANE_REGS; i++)
      write_reg(PLANE_IDX[i], plane_plan[i], i == NUM_PLANE_REGS - 1);
  endtask

  function automatic plane_t mk_plane(int nx, int ny, int nz, int d);
    plane_t p;
    p.nx = NORM_W'(nx);
    p.ny = NORM_W'(ny);
    p.nz = NORM_W'(nz);
    p.d  = OFS_W'(d);
    return p;
  endfunction

  // axis-aligned view volume of half size h around (cx, cy, cz)
  task automatic plan_cube(int cx, int cy, int cz, int h);
    plane_plan[0] = mk_plane(0, 0, ONE, h - cz);
    plane_plan[1] = mk_plane(0, 0, -ONE, h + cz);
    plane_plan[2] = mk_plane(ONE, 0, 0, h - cx);
    plane_plan[3] = mk_plane(-ONE, 0, 0, h + cx);
    plane_plan[4] = mk_plane(0, -ONE, 0, h + cy);
    plane_plan[5] = mk_plane(0, ONE, 0, h - cy);
  endtask

  function automatic box_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.min_x = CW'(x0);  b.min_y = CW'(y0);  b.min_z = CW'(z0);
    b.max_x = CW'(x1);  b.max_y = CW'(y1);  b.max_z = CW'(z1);
    return b;
  endfunction

  function automatic logic [CW-1:0] clip(int v);
    int hi;
    int lo;
    hi = (1 <<< (CW - 1)) - 1;
    lo = -(1 <<< (CW - 1));
    return CW'((v > hi) ? hi : (v < lo) ? lo : v);
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // box near a center, sometimes with swapped corners, sometimes raw random bits
  function automatic box_t rand_box(int cx, int cy, int cz, int span, int ext);
    logic [CW-1:0] v [6];
    logic [CW-1:0] t;
    int            ctr [3];
    ctr[0] = cx;  ctr[1] = cy;  ctr[2] = cz;
    if ($urandom_range(0, 99) < 15) begin
      foreach (v[i]) v[i] = CW'($urandom);
    end else begin
      for (int a = 0; a < 3; a++) begin
        ctr[a]   = ctr[a] + spread(span);
        v[a]     = clip(ctr[a] - int'($urandom_range(0, ext)));
        v[a + 3] = clip(ctr[a] + int'($urandom_range(0, ext)));
        if ($urandom_range(0, 99) < 15) begin
          t = v[a];  v[a] = v[a + 3];  v[a + 3] = t;
        end
      end
    end
    return mk_box(int'($signed(v[0])), int'($signed(v[1])), int'($signed(v[2])),
                  int'($signed(v[3])), int'($signed(v[4])), int'($signed(v[5])));
  endfunction

  // planes clear on reset, so everything must come back culled
  task automatic test_reset_state();
    send_box(mk_box(-16, -16, -16, 16, 16, 16));
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_cube_directed();
    settle();
    plan_cube(0, 0, 0, 160);
    load_planes();
    send_box(mk_box(-16, -16, -16, 16, 16, 16));
    send_box(mk_box(400, -16, -16, 500, 16, 16));
    send_box(mk_box(100, -16, -16, 300, 16, 16));
    // corner lands exactly on the left plane: zero distance counts as outside
    send_box(mk_box(-300, -16, -16, -160, 16, 16));
    send_box(mk_box(-300, -16, -16, -159, 16, 16));
    send_box(mk_box(16, 16, 16, -16, -16, -16));
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
  endtask

  // writes past the last plane register leave the planes alone
  task automatic test_ignored_index();
    settle();
    write_reg(NO_REG_LO, '1, 1'b0);
    write_reg(NO_REG_HI, {$urandom, $urandom}, 1'b1);
    send_box(mk_box(-16, -16, -16, 16, 16, 16));
    send_box(mk_box(400, 400, 400, 500, 500, 500));
    send_box(mk_box(-200, -16, -16, 0, 16, 16));
  endtask

  task automatic test_extreme_planes();
    settle();
    plane_plan[0] = mk_plane(32767, -32768, 32767, -32768);
    plane_plan[1] = mk_plane(-32768, 32767, -32768, 32767);
    for (int i = 2; i < NUM_PLANE_REGS; i++) plane_plan[i] = mk_plane(0, 0, 0, 32767);
    load_planes();
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(32767, -32768, 32767, -32768, 32767, -32768));
    settle();
    for (int i = 0; i < NUM_PLANE_REGS; i++) plane_plan[i] = '1;
    load_planes();
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random();
    int kind;
    int h;
    int cx, cy, cz;
    int span, ext;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      kind      = (ph < 5) ? ph : $urandom_range(0, 4);
      tx_idles  = (ph % 3) != 2;
      rx_stalls = (ph % 3) != 2;
      h    = $urandom_range(16, 8000);
      cx   = spread(32767 - h);
      cy   = spread(32767 - h);
      cz   = spread(32767 - h);
      span = 2 * h;
      ext  = h / 2 + 1;
      plan_cube(cx, cy, cz, h);
      case (kind)
        1: begin
          // tilted view volume: perturb every normal component
          for (int i = 0; i < NUM_PLANE_REGS; i++) begin
            plane_plan[i].nx = NORM_W'(int'(plane_plan[i].nx) + spread(3000));
            plane_plan[i].ny = NORM_W'(int'(plane_plan[i].ny) + spread(3000));
            plane_plan[i].nz = NORM_W'(int'(plane_plan[i].nz) + spread(3000));
          end
        end
        2: begin
          for (int i = 0; i < NUM_PLANE_REGS; i++)
            plane_plan[i] = mk_plane($urandom, $urandom, $urandom, $urandom);
          cx = 0;  cy = 0;  cz = 0;  span = 32767;  ext = 4000;
        end
        3: begin
          // some planes wide open, the rest from the cube
          for (int i = 0; i < NUM_PLANE_REGS; i++)
            if ($urandom_range(0, 1) == 1)
              plane_plan[i] = mk_plane(0, 0, 0, $urandom_range(1, 32767));
        end
        4: begin
          for (int i = 0; i < NUM_PLANE_REGS; i++) plane_plan[i] = {$urandom, $urandom};
          cx = 0;  cy = 0;  cz = 0;  span = 32767;  ext = 8000;
        end
        default: ;
      endcase
      load_planes();
      for (int n = 0; n < PHASE_BOXES; n++) send_box(rand_box(cx, cy, cz, span, ext));
    end
    tx_idles  = 1'b1;
    rx_stalls = 1'b1;
  endtask

  initial begin
    foreach (plane_regs[i]) plane_regs[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_cube_directed();
    test_ignored_index();
    test_extreme_planes();
    test_random();
    settle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== frustum_aabb_cull_test_core.f =====
design/fcull_pkg.sv
design/fcull_cfg_regs.sv
design/fcull_plane_eval.sv
design/frustum_aabb_cull_test_core.sv
sim/tb_frustum_aabb_cull_test_core.sv
